// ----- rtl/swdsr_pkg.sv -----
`default_nettype none
package swdsr_pkg;

    localparam int STACK_DEPTH   = 1024;
    localparam int ADDR_W        = $clog2(STACK_DEPTH);
    localparam int CNT_W         = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W        = 32;
    localparam int CMD_W         = 3;
    localparam int OFF_W         = 10;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_COUNT_W = 11;
    localparam int CMP_W         = (CNT_W > OFF_W) ? CNT_W : OFF_W;

    // top-of-stack cache depth (cells)
    localparam int NUM_CELLS     = 3;
    localparam int CELL_IDX_W    = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 3'd0,
        CMD_POP  = 3'd1,
        CMD_DUP  = 3'd2,
        CMD_SWAP = 3'd3,
        CMD_ROT  = 3'd4,
        CMD_PEEK = 3'd5
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2
    } t_status;

    // hold, load from the neighbor above, load from the neighbor below
    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_UP   = 2'd1,
        CELL_DOWN = 2'd2
    } t_cell_op;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] push_value;
        logic [OFF_W-1:0]  peek_offset;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0]        read_value;
        logic [STATUS_W-1:0]      status;
        logic [ENTRY_COUNT_W-1:0] entry_count;
    } t_out_item;

endpackage
`default_nettype wire

// ----- rtl/stack_with_dup_swap_rot_top.sv -----
`default_nettype none
// LIFO data stack with push, pop, dup, swap, rot and peek. A command is
// taken when i_start is high and o_busy is low; exactly one result follows
// on o_out_item, marked by o_valid for one cycle, on the cycle after the
// command's execute cycle. The receiver cannot stall: a result must be taken
// when o_valid is high. A command is accepted and then executed; o_busy is
// high during execute, so the next command waits, since the registered read
// of the entry RAM supplies the refill entry for pop and deep peeks.
// No clearing pass is needed after reset.
module stack_with_dup_swap_rot_top (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire swdsr_pkg::t_in_item  i_in_item,
    output logic                      o_busy,
    output logic                      o_valid,
    output swdsr_pkg::t_out_item      o_out_item
);

    // Storage split: the top three entries live in a chain of cells
    // (cell 0 is the top); every entry below them lives in the RAM at its
    // own stack index. Push/dup spill cell 2 into the RAM, pop refills
    // cell 2 from the RAM. Swap and rot touch the cells only.

    logic [swdsr_pkg::DATA_W-1:0] mem [swdsr_pkg::STACK_DEPTH];
    logic [swdsr_pkg::DATA_W-1:0] r_rdata;

    logic [swdsr_pkg::CNT_W-1:0]  r_depth;
    logic [swdsr_pkg::CNT_W-1:0]  n_depth;
    logic                         r_busy;
    logic                         r_valid;
    swdsr_pkg::t_in_item          r_item;
    swdsr_pkg::t_out_item         r_out;
    swdsr_pkg::t_out_item         n_out;

    logic                         w_accept;
    logic [swdsr_pkg::ADDR_W-1:0] w_rd_addr;
    logic [swdsr_pkg::ADDR_W-1:0] w_wr_addr;
    logic                         w_wr_en;
    logic [swdsr_pkg::CMP_W-1:0]  w_in_off_ext;
    logic [swdsr_pkg::CMP_W-1:0]  w_off_ext;
    logic [swdsr_pkg::CMP_W-1:0]  w_depth_ext;
    logic                         w_full;

    logic [swdsr_pkg::DATA_W-1:0] w_cell [swdsr_pkg::NUM_CELLS];
    logic [swdsr_pkg::DATA_W-1:0] w_up   [swdsr_pkg::NUM_CELLS];
    logic [swdsr_pkg::DATA_W-1:0] w_down [swdsr_pkg::NUM_CELLS];
    swdsr_pkg::t_cell_op          w_op   [swdsr_pkg::NUM_CELLS];

    assign w_accept    = i_start && !r_busy;
    assign w_depth_ext = swdsr_pkg::CMP_W'(r_depth);
    assign w_in_off_ext = swdsr_pkg::CMP_W'(i_in_item.peek_offset);
    assign w_off_ext   = swdsr_pkg::CMP_W'(r_item.peek_offset);
    assign w_full      = (r_depth >= swdsr_pkg::CNT_W'(swdsr_pkg::STACK_DEPTH));

    // RAM read address, chosen at accept: peek target, or the pop refill
    // entry (index depth-4). Out-of-range addresses are never used.
    always_comb begin
        if (i_in_item.cmd == swdsr_pkg::CMD_PEEK) begin
            w_rd_addr = swdsr_pkg::ADDR_W'(w_depth_ext - w_in_off_ext
                                           - swdsr_pkg::CMP_W'(1));
        end else begin
            w_rd_addr = swdsr_pkg::ADDR_W'(r_depth - swdsr_pkg::CNT_W'(4));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rdata <= mem[w_rd_addr];
            r_item  <= i_in_item;
        end
        if (w_wr_en) begin
            mem[w_wr_addr] <= w_cell[2];
        end
    end

    // Cell chain wiring. Cell 0's upper input carries the pushed value,
    // or cell 2 for rot; cell 2's lower input is the RAM refill.
    assign w_up[0]   = (r_item.cmd == swdsr_pkg::CMD_ROT) ? w_cell[2]
                                                           : r_item.push_value;
    assign w_up[1]   = w_cell[0];
    assign w_up[2]   = w_cell[1];
    assign w_down[0] = w_cell[1];
    assign w_down[1] = w_cell[2];
    assign w_down[2] = r_rdata;

    for (genvar g = 0; g < swdsr_pkg::NUM_CELLS; g++) begin : g_cell
        swdsr_cell u_cell (
            .i_clk       (i_clk),
            .i_op        (w_op[g]),
            .i_up_data   (w_up[g]),
            .i_down_data (w_down[g]),
            .o_data      (w_cell[g])
        );
    end

    // Execute: decode on the cycle after accept.
    always_comb begin
        n_out.read_value = '0;
        n_out.status     = swdsr_pkg::ST_OK;
        n_depth          = r_depth;
        w_wr_en          = 1'b0;
        w_wr_addr        = swdsr_pkg::ADDR_W'(r_depth - swdsr_pkg::CNT_W'(3));
        for (int i = 0; i < swdsr_pkg::NUM_CELLS; i++) begin
            w_op[i] = swdsr_pkg::CELL_HOLD;
        end

        if (r_busy) begin
            case (r_item.cmd)
                swdsr_pkg::CMD_PUSH: begin
                    if (w_full) begin
                        n_out.status = swdsr_pkg::ST_OVER;
                    end else begin
                        for (int i = 0; i < swdsr_pkg::NUM_CELLS; i++) begin
                            w_op[i] = swdsr_pkg::CELL_UP;
                        end
                        w_wr_en = (r_depth >= swdsr_pkg::CNT_W'(3));
                        n_depth = r_depth + swdsr_pkg::CNT_W'(1);
                    end
                end
                swdsr_pkg::CMD_POP: begin
                    if (r_depth == '0) begin
                        n_out.status = swdsr_pkg::ST_UNDER;
                    end else begin
                        for (int i = 0; i < swdsr_pkg::NUM_CELLS; i++) begin
                            w_op[i] = swdsr_pkg::CELL_DOWN;
                        end
                        n_out.read_value = w_cell[0];
                        n_depth = r_depth - swdsr_pkg::CNT_W'(1);
                    end
                end
                swdsr_pkg::CMD_DUP: begin
                    if (r_depth == '0) begin
                        n_out.status = swdsr_pkg::ST_UNDER;
                    end else if (w_full) begin
                        n_out.status = swdsr_pkg::ST_OVER;
                    end else begin
                        w_op[1] = swdsr_pkg::CELL_UP;
                        w_op[2] = swdsr_pkg::CELL_UP;
                        w_wr_en = (r_depth >= swdsr_pkg::CNT_W'(3));
                        n_depth = r_depth + swdsr_pkg::CNT_W'(1);
                    end
                end
                swdsr_pkg::CMD_SWAP: begin
                    if (r_depth < swdsr_pkg::CNT_W'(2)) begin
                        n_out.status = swdsr_pkg::ST_UNDER;
                    end else begin
                        w_op[0] = swdsr_pkg::CELL_DOWN;
                        w_op[1] = swdsr_pkg::CELL_UP;
                    end
                end
                swdsr_pkg::CMD_ROT: begin
                    if (r_depth < swdsr_pkg::CNT_W'(3)) begin
                        n_out.status = swdsr_pkg::ST_UNDER;
                    end else begin
                        for (int i = 0; i < swdsr_pkg::NUM_CELLS; i++) begin
                            w_op[i] = swdsr_pkg::CELL_UP;
                        end
                    end
                end
                swdsr_pkg::CMD_PEEK: begin
                    if (w_off_ext >= w_depth_ext) begin
                        n_out.status = swdsr_pkg::ST_UNDER;
                    end else if (w_off_ext < swdsr_pkg::CMP_W'(swdsr_pkg::NUM_CELLS)) begin
                        case (r_item.peek_offset[swdsr_pkg::CELL_IDX_W-1:0])
                            swdsr_pkg::CELL_IDX_W'(0): n_out.read_value = w_cell[0];
                            swdsr_pkg::CELL_IDX_W'(1): n_out.read_value = w_cell[1];
                            default:                   n_out.read_value = w_cell[2];
                        endcase
                    end else begin
                        n_out.read_value = r_rdata;
                    end
                end
                default: begin
                    // unused codes: no effect
                end
            endcase
        end
        n_out.entry_count = swdsr_pkg::ENTRY_COUNT_W'(n_depth);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_depth <= n_depth;
            r_busy  <= w_accept;
            r_valid <= r_busy;
        end
        if (r_busy) begin
            r_out <= n_out;
        end
    end

    assign o_busy     = r_busy;
    assign o_valid    = r_valid;
    assign o_out_item = r_out;

    // Each accepted transaction yields a result strobe after its execute cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> ##1 r_valid)
        else $error("result strobe missing after transaction");

    // A result never shares a cycle with execute, so busy is low.
    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !r_busy)
        else $error("result strobe during execute");

    // Entry count stays in range.
    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= swdsr_pkg::CNT_W'(swdsr_pkg::STACK_DEPTH))
        else $error("entry count out of range");

    // A failed command leaves the count unchanged.
    a_error_keeps_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_out.status != swdsr_pkg::ST_OK)) |-> r_depth == $past(r_depth))
        else $error("failed command changed the entry count");

    // Count moves only on execute.
    a_depth_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |=> $stable(r_depth))
        else $error("entry count changed outside execute");

endmodule
`default_nettype wire

// ----- rtl/swdsr_cell.sv -----
`default_nettype none
// One stack entry of the top-of-stack chain.
module swdsr_cell (
    input  wire logic                          i_clk,
    input  wire swdsr_pkg::t_cell_op           i_op,
    input  wire logic [swdsr_pkg::DATA_W-1:0]  i_up_data,
    input  wire logic [swdsr_pkg::DATA_W-1:0]  i_down_data,
    output logic [swdsr_pkg::DATA_W-1:0]       o_data
);

    logic [swdsr_pkg::DATA_W-1:0] r_data;
    logic [swdsr_pkg::DATA_W-1:0] n_data;

    always_comb begin
        case (i_op)
            swdsr_pkg::CELL_UP:   n_data = i_up_data;
            swdsr_pkg::CELL_DOWN: n_data = i_down_data;
            default:              n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule
`default_nettype wire
